// File: src/pal_pkg.sv
// Shared constants, codes and controller/datapath interface types for the positional array list.
package pal_pkg;

    // Built depth of the entry store and derived widths
    localparam int DEPTH  = 128;
    localparam int WORD_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;

    // Operation codes
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;   // capture the accepted word
        logic init_ptr;  // start the shift pointer
        logic rd_src;    // read the neighbour entry to move
        logic wr_shift;  // write the moved entry at the pointer
        logic put;       // write the new word at the position
        logic rd_pos;    // read the entry at the position
        logic cnt_inc;
        logic cnt_dec;
        logic load_out;  // load the result register
    } pal_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] code;
        logic [1:0] kind;
        logic       more;  // entries still to move
    } pal_stat_t;

endpackage

// File: src/pal_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/pal_dp.sv
// Datapath: word capture, entry store, shift pointer, count, limit register and result word.
module pal_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [7:0]                    cfg_wr_data,
    input  logic [1:0]                    kind,
    input  logic [7:0]                    position,
    input  logic signed [31:0]            item_value,
    input  pal_pkg::pal_cmd_t             cmd,
    output pal_pkg::pal_stat_t            stat,
    output logic [1:0]                    status,
    output logic signed [31:0]            read_value,
    output logic [7:0]                    entry_count
);

    import pal_pkg::*;

    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    logic [7:0]        cap_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [1:0]        kind_reg;
    logic [7:0]        pos_reg;
    logic [WORD_W-1:0] val_reg;
    logic [CMP_W-1:0]  ptr_reg;
    logic [CMP_W-1:0]  ptr_next;
    logic              ok_reg;
    logic [1:0]        status_reg;
    logic [WORD_W-1:0] rdval_reg;
    logic [7:0]        cnt_out_reg;

    logic [CMP_W-1:0]  count_ext;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  lim_eff;
    logic [1:0]        code;
    logic              more;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CMP_W-1:0]  src_idx;
    logic [WORD_W-1:0] ram_rdata;

    assign count_ext = CMP_W'(count_reg);
    assign pos_ext   = CMP_W'(pos_reg);
    assign cap_ext   = CMP_W'(cap_reg);
    assign lim_eff   = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;

    // Classify the held word
    always_comb
    begin
        code = ST_OK;
        case (kind_reg)
            KIND_INSERT:
            begin
                if (count_ext >= lim_eff)
                    code = ST_FULL;
                else if (pos_ext > count_ext)
                    code = ST_BADPOS;
            end
            KIND_DELETE, KIND_READ:
            begin
                if (count_reg == '0)
                    code = ST_EMPTY;
                else if (pos_ext >= count_ext)
                    code = ST_BADPOS;
            end
            default:
            begin
                code = ST_BADPOS;
            end
        endcase
    end

    // Insert moves from the top down to the position, delete from the position up
    assign more = (kind_reg == KIND_INSERT) ? (ptr_reg > pos_ext)
                                            : ((ptr_reg + 1'b1) < count_ext);

    assign stat.code = code;
    assign stat.kind = kind_reg;
    assign stat.more = more;

    // Entry store addressing
    assign src_idx   = (kind_reg == KIND_INSERT) ? (ptr_reg - 1'b1) : (ptr_reg + 1'b1);
    assign ram_re    = cmd.rd_src | cmd.rd_pos;
    assign ram_raddr = cmd.rd_src ? src_idx[ADDR_W-1:0] : pos_ext[ADDR_W-1:0];
    assign ram_we    = cmd.wr_shift | cmd.put;
    assign ram_waddr = cmd.wr_shift ? ptr_reg[ADDR_W-1:0] : pos_ext[ADDR_W-1:0];
    assign ram_wdata = cmd.wr_shift ? ram_rdata : val_reg;

    pal_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Start the pointer, then advance it after each move
    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.init_ptr)
            ptr_next = (kind_reg == KIND_INSERT) ? count_ext : pos_ext;
        else if (cmd.wr_shift)
            ptr_next = (kind_reg == KIND_INSERT) ? (ptr_reg - 1'b1) : (ptr_reg + 1'b1);
    end

    // Hold the limit register and the count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= 8'd128;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            if (cmd.cnt_inc)
                count_reg <= count_reg + 1'b1;
            else if (cmd.cnt_dec)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Capture the word, the pointer and the result
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg <= kind;
            pos_reg  <= position;
            val_reg  <= item_value;
        end
        // Remember that a word passed its checks before the count moves on
        if (cmd.load_in)
            ok_reg <= 1'b0;
        else if (cmd.init_ptr)
            ok_reg <= 1'b1;
        ptr_reg <= ptr_next;
        if (cmd.load_out)
        begin
            status_reg  <= ok_reg ? ST_OK : code;
            rdval_reg   <= ((kind_reg == KIND_READ) && (code == ST_OK)) ? ram_rdata : '0;
            cnt_out_reg <= count_ext[7:0];
        end
    end

    assign status      = status_reg;
    assign read_value  = rdval_reg;
    assign entry_count = cnt_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_ext <= DEPTH_C)
        else $error("entry count beyond built depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + 1'b1) || (count_reg == $past(count_reg) - 1'b1)))
        else $error("entry count moved by more than one");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_shift |-> (ptr_reg < DEPTH_C))
        else $error("shift write outside the entry store");

endmodule

// File: src/pal_ctrl.sv
// Controller: sequences each word through classify, then shift and write where needed, and result hand-off.
module pal_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  pal_pkg::pal_stat_t stat,
    output pal_pkg::pal_cmd_t  cmd
);

    import pal_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_CHECK,
        S_MV_RD,
        S_MV_WR,
        S_PUT,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.code != ST_OK)
                    state_next = S_DONE;
                else if (stat.kind == KIND_READ)
                begin
                    cmd.rd_pos = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.init_ptr = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.more)
                    state_next = S_MV_RD;
                else if (stat.kind == KIND_INSERT)
                    state_next = S_PUT;
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_MV_RD:
            begin
                cmd.rd_src = 1'b1;
                state_next = S_MV_WR;
            end
            S_MV_WR:
            begin
                cmd.wr_shift = 1'b1;
                state_next   = S_CHECK;
            end
            S_PUT:
            begin
                cmd.put     = 1'b1;
                cmd.cnt_inc = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    a_reject_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DECIDE) && (stat.code != ST_OK)) |=>
            ((state_reg == S_DONE) && !cmd.put && !cmd.wr_shift))
        else $error("rejected word reached the entry store");

    a_put_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put |=> !cmd.put)
        else $error("new word written twice");

endmodule

// File: src/positional_array_list.sv
// Top level of the positional array list: bounded ordered list of signed 32-bit words.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    kind, position, item_value
//   out       output     out_valid/out_ready  status, read_value, entry_count
//   cfg       input      cfg_wr_en            cfg_wr_data (capacity limit)
//
// Read and rejected words go from classification straight to the result; an insert at
// position p with n entries first moves n-p of them, a delete n-1-p.
// Each moved entry costs one read and one write through the single pair of
// entry store ports, plus one pointer check.
// Reset empties the list and sets the limit to 128; entry contents are not cleared.
// A new word is taken while the previous result waits in the output register.
module positional_array_list (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [7:0]         position,
    input  logic signed [31:0] item_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [31:0] read_value,
    output logic [7:0]         entry_count
);

    import pal_pkg::*;

    pal_cmd_t  cmd;
    pal_stat_t stat;

    pal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pal_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .kind        (kind),
        .position    (position),
        .item_value  (item_value),
        .cmd         (cmd),
        .stat        (stat),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count)
    );

endmodule
